// ===== rtl/core/mbt_pkg.sv =====
package mbt_pkg;

    // Default word layout of a point: signed Q4.28.
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 28;

    // Iteration limit register.
    localparam int                   ITER_BITS      = 10;
    localparam logic [ITER_BITS-1:0] RESET_MAX_ITER = 10'd100;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture c, clear z and the step count
        logic mul;      // register the three products of the current z
        logic step;     // write z*z + c back to z and advance the count
        logic finish;   // load the result register
        logic in_set;   // flag that goes with finish
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic escaped;     // |z|^2 > 4 for the registered products
        logic last;        // the next update is the final one allowed
        logic limit_zero;  // the iteration limit is zero
    } t_status;

endpackage

// ===== rtl/core/mbt_point_if.sv =====
interface mbt_point_if #(
    parameter int WORD_BITS = mbt_pkg::WORD_BITS
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] point_re;
    logic signed [WORD_BITS-1:0] point_im;

    modport source (output valid, output point_re, output point_im, input ready);
    modport sink   (input valid, input point_re, input point_im, output ready);
endinterface

// ===== rtl/core/mbt_result_if.sv =====
interface mbt_result_if #(
    parameter int WORD_BITS = mbt_pkg::WORD_BITS
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] result_re;
    logic signed [WORD_BITS-1:0] result_im;
    logic                        in_set;

    modport source (output valid, output result_re, output result_im, output in_set,
                    input ready);
    modport sink   (input valid, input result_re, input result_im, input in_set,
                    output ready);
endinterface

// ===== rtl/core/mandelbrot_membership_test.sv =====
// Mandelbrot membership test for one complex point c at a time.
// Points arrive on the i_point channel (point_re, point_im, signed fixed point with
// FRAC_BITS fraction bits) and one result per point leaves on o_result: the point
// echoed and in_set, which is 1 when no escape (|z|^2 > 4) was seen within
// max_iterations updates of z = z*z + c. The limit is written through i_cfg_wr_en and
// i_cfg_wr_data; the user is to write it only while the block is idle, which the
// block itself does not enforce. Reset sets it to 100. Each iteration passes through
// a multiply state, in which the three products of z are formed and registered, and
// an update state for the escape test, the add of c and the saturation of both parts.
// A point needs one escape test for each of its updates, plus the test that finds the
// escape if there is one; a zero limit skips the iterations and goes straight to the
// finish state.
// One point is in work at a time; the next transfer on i_point is taken as soon as
// the previous result sits in the output register, even while that result still
// waits for the receiver. If the receiver stalls, the finished point holds in the
// controller until the output register frees up, and i_point stays closed meanwhile.
// Synchronous reset clears the controller, drops o_result.valid and restores the
// iteration limit.
module mandelbrot_membership_test #(
    parameter int WORD_BITS = mbt_pkg::WORD_BITS,
    parameter int FRAC_BITS = mbt_pkg::FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [mbt_pkg::ITER_BITS-1:0] i_cfg_wr_data,
    mbt_point_if.sink                     i_point,
    mbt_result_if.source                  o_result
);

    mbt_pkg::t_cmd    cmd;
    mbt_pkg::t_status status;

    // The controller sequences multiply and update cycles; the datapath holds z,
    // the point, the step count and the output register.
    mbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_point.valid),
        .o_in_ready  (i_point.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mbt_datapath #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_point_re    (i_point.point_re),
        .i_point_im    (i_point.point_im),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_result_re   (o_result.result_re),
        .o_result_im   (o_result.result_im),
        .o_in_set      (o_result.in_set)
    );

endmodule

// ===== rtl/core/mbt_ctrl.sv =====
module mbt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  mbt_pkg::t_status  i_status,
    output mbt_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_flag, n_flag;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_flag      = r_flag;
        n_out_valid = r_out_valid & ~i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.limit_zero) begin
                        n_flag  = 1'b1;
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_UPD;
            end
            ST_UPD: begin
                if (i_status.escaped) begin
                    n_flag  = 1'b0;
                    n_state = ST_FIN;
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_status.last) begin
                        n_flag  = 1'b1;
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        o_cmd.in_set = r_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_flag      <= n_flag;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/mbt_datapath.sv =====
module mbt_datapath #(
    parameter int WORD_BITS = mbt_pkg::WORD_BITS,
    parameter int FRAC_BITS = mbt_pkg::FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [mbt_pkg::ITER_BITS-1:0]       i_cfg_wr_data,
    input  logic signed [WORD_BITS-1:0]         i_point_re,
    input  logic signed [WORD_BITS-1:0]         i_point_im,
    input  mbt_pkg::t_cmd                       i_cmd,
    output mbt_pkg::t_status                    o_status,
    output logic signed [WORD_BITS-1:0]         o_result_re,
    output logic signed [WORD_BITS-1:0]         o_result_im,
    output logic                                o_in_set
);

    localparam int PW = 2 * WORD_BITS;
    localparam int IB = mbt_pkg::ITER_BITS;
    // Escape radius 2: |z|^2 > 4 in units of 2^(2*FRAC_BITS).
    localparam logic signed [PW:0] ESC_LIMIT = (PW+1)'(1) << (2 * FRAC_BITS + 2);
    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic [IB-1:0]               r_max_iter;
    logic [IB-1:0]               r_count;
    logic signed [WORD_BITS-1:0] r_cr, r_ci;
    logic signed [WORD_BITS-1:0] r_zr, r_zi;
    logic signed [PW-1:0]        r_rr, r_ii, r_ri;
    logic signed [WORD_BITS-1:0] r_res_re, r_res_im;
    logic                        r_res_set;

    logic signed [PW-1:0]        p_rr, p_ii, p_ri;
    logic signed [PW:0]          mag_sq, sq_diff, re_shift;
    logic signed [PW+1:0]        re_sum;
    logic signed [PW-1:0]        im_shift;
    logic signed [PW:0]          im_sum;
    logic signed [WORD_BITS-1:0] n_zr, n_zi;

    // Clamp a wide signed value into the word range.
    function automatic logic signed [WORD_BITS-1:0] sat_re(input logic signed [PW+1:0] v);
        logic [PW+2-WORD_BITS:0] top;
        top = v[PW+1:WORD_BITS-1];
        if ((&top) || !(|top)) begin
            sat_re = v[WORD_BITS-1:0];
        end else begin
            sat_re = v[PW+1] ? WORD_MIN : WORD_MAX;
        end
    endfunction

    function automatic logic signed [WORD_BITS-1:0] sat_im(input logic signed [PW:0] v);
        logic [PW+1-WORD_BITS:0] top;
        top = v[PW:WORD_BITS-1];
        if ((&top) || !(|top)) begin
            sat_im = v[WORD_BITS-1:0];
        end else begin
            sat_im = v[PW] ? WORD_MIN : WORD_MAX;
        end
    endfunction

    // Multiply stage: three full-width signed products.
    assign p_rr = r_zr * r_zr;
    assign p_ii = r_zi * r_zi;
    assign p_ri = r_zr * r_zi;

    // Update stage: escape test and the next z from the registered products.
    assign mag_sq   = {r_rr[PW-1], r_rr} + {r_ii[PW-1], r_ii};
    assign sq_diff  = {r_rr[PW-1], r_rr} - {r_ii[PW-1], r_ii};
    assign re_shift = sq_diff >>> FRAC_BITS;
    assign re_sum   = {re_shift[PW], re_shift} + {{(PW+2-WORD_BITS){r_cr[WORD_BITS-1]}}, r_cr};
    assign im_shift = r_ri >>> (FRAC_BITS - 1);
    assign im_sum   = {im_shift[PW-1], im_shift}
                    + {{(PW+1-WORD_BITS){r_ci[WORD_BITS-1]}}, r_ci};
    assign n_zr     = sat_re(re_sum);
    assign n_zi     = sat_im(im_sum);

    assign o_status.escaped    = (mag_sq > ESC_LIMIT);
    assign o_status.last       = (({1'b0, r_count} + (IB+1)'(1)) == {1'b0, r_max_iter});
    assign o_status.limit_zero = (r_max_iter == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= mbt_pkg::RESET_MAX_ITER;
            r_count    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_iter <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_count <= '0;
            end else if (i_cmd.step) begin
                r_count <= r_count + IB'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cr <= i_point_re;
            r_ci <= i_point_im;
            r_zr <= '0;
            r_zi <= '0;
        end else if (i_cmd.step) begin
            r_zr <= n_zr;
            r_zi <= n_zi;
        end
        if (i_cmd.mul) begin
            r_rr <= p_rr;
            r_ii <= p_ii;
            r_ri <= p_ri;
        end
        if (i_cmd.finish) begin
            r_res_re  <= r_cr;
            r_res_im  <= r_ci;
            r_res_set <= i_cmd.in_set;
        end
    end

    assign o_result_re = r_res_re;
    assign o_result_im = r_res_im;
    assign o_in_set    = r_res_set;

endmodule

// ===== rtl/core/mbt_checker.sv =====
module mbt_checker #(
    parameter int WORD_BITS = mbt_pkg::WORD_BITS
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic signed [WORD_BITS-1:0] i_result_re,
    input logic signed [WORD_BITS-1:0] i_result_im,
    input logic                        i_in_set
);

    // After reset the block is empty and ready for a point.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("block not empty after reset");

    // Only one point is in work: a transfer in closes the input side.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second point taken while one is in work");

    // A result never appears in the cycle right after its point was taken.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result shown too early");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_result_re) && $stable(i_result_im)
             && $stable(i_in_set)))
        else $error("stalled result changed");

endmodule

bind mandelbrot_membership_test mbt_checker #(
    .WORD_BITS (WORD_BITS)
) u_mbt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_point.valid),
    .i_in_ready  (i_point.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_result_re (o_result.result_re),
    .i_result_im (o_result.result_im),
    .i_in_set    (o_result.in_set)
);
